/* src/ookpwc_pkg.sv */
// ----------------------------------------------------------------------------
// ookpwc_pkg
// Shared widths, codes and reset values for the OOK pulse width classifier.
// ----------------------------------------------------------------------------
package ookpwc_pkg;

   localparam int TIME_W  = 32;
   localparam int WIDTH_W = 16;
   localparam int RSSI_W  = 8;
   localparam int GAP_W   = 20;
   localparam int CNT_W   = 16;
   localparam int CLASS_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [CLASS_W-1:0] class_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   // item kinds
   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_POLL = 1'b1;

   // pulse classes
   localparam class_type CLASS_NONE    = 3'd0;
   localparam class_type CLASS_SHORT   = 3'd1;
   localparam class_type CLASS_LONG    = 3'd2;
   localparam class_type CLASS_INVALID = 3'd3;
   localparam class_type CLASS_GAP     = 3'd4;

   // register indexes
   localparam csr_index_type CSR_SHORT_MIN     = 3'd0;
   localparam csr_index_type CSR_SHORT_MAX     = 3'd1;
   localparam csr_index_type CSR_LONG_MIN      = 3'd2;
   localparam csr_index_type CSR_LONG_MAX      = 3'd3;
   localparam csr_index_type CSR_TRIGGER_LEVEL = 3'd4;
   localparam csr_index_type CSR_WINDOW_POLLS  = 3'd5;
   localparam csr_index_type CSR_GAP_LIMIT     = 3'd6;

   // register reset values
   localparam logic [WIDTH_W-1:0] RST_SHORT_MIN     = 16'd390;
   localparam logic [WIDTH_W-1:0] RST_SHORT_MAX     = 16'd600;
   localparam logic [WIDTH_W-1:0] RST_LONG_MIN      = 16'd850;
   localparam logic [WIDTH_W-1:0] RST_LONG_MAX      = 16'd1200;
   localparam logic [RSSI_W-1:0]  RST_TRIGGER_LEVEL = 8'd180;
   localparam logic [WIDTH_W-1:0] RST_WINDOW_POLLS  = 16'd4000;
   localparam logic [GAP_W-1:0]   RST_GAP_LIMIT     = 20'd6144;

   function automatic count_type sat_inc(input count_type v);
      count_type r;
      r = (v == '1) ? v : v + count_type'(1);
      return r;
   endfunction

endpackage

/* src/ook_pulse_width_classifier_top.sv */
// ----------------------------------------------------------------------------
// ook_pulse_width_classifier_top
// Classifies OOK edge intervals and runs RSSI-triggered capture windows.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  func, time_us, rssi_byte
//   rsp      out        rsp_valid / rsp_stall  marker, pulse_class, armed,
//                                              report, edge/short/long totals
//   csr      in         csr_write              csr_index, csr_wdata
//
// One transfer per cycle sustained while rsp_stall is low; each request passes
// through the input register and then the result register.
// Synchronous reset clears state, counters and restores register defaults.
// rsp_stall holds the result register and backs up into req_stall only when
// both the input register and the result register are full.
// ----------------------------------------------------------------------------
module ook_pulse_width_classifier_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [ookpwc_pkg::TIME_W-1:0]     req_time_us,
   input  logic [ookpwc_pkg::RSSI_W-1:0]     req_rssi_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_marker,
   output logic [ookpwc_pkg::CLASS_W-1:0]    rsp_pulse_class,
   output logic                              rsp_armed,
   output logic                              rsp_report,
   output logic [ookpwc_pkg::CNT_W-1:0]      rsp_edge_total,
   output logic [ookpwc_pkg::CNT_W-1:0]      rsp_short_total,
   output logic [ookpwc_pkg::CNT_W-1:0]      rsp_long_total,
   input  logic                              csr_write,
   input  logic [ookpwc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ookpwc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ookpwc_pkg::*;

   // configuration
   logic [WIDTH_W-1:0] short_min_ff, short_max_ff, long_min_ff, long_max_ff;
   logic [WIDTH_W-1:0] window_polls_ff;
   logic [RSSI_W-1:0]  trigger_level_ff;
   logic [GAP_W-1:0]   gap_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_min_ff     <= RST_SHORT_MIN;
         short_max_ff     <= RST_SHORT_MAX;
         long_min_ff      <= RST_LONG_MIN;
         long_max_ff      <= RST_LONG_MAX;
         trigger_level_ff <= RST_TRIGGER_LEVEL;
         window_polls_ff  <= RST_WINDOW_POLLS;
         gap_limit_ff     <= RST_GAP_LIMIT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SHORT_MIN:     short_min_ff     <= csr_wdata[WIDTH_W-1:0];
            CSR_SHORT_MAX:     short_max_ff     <= csr_wdata[WIDTH_W-1:0];
            CSR_LONG_MIN:      long_min_ff      <= csr_wdata[WIDTH_W-1:0];
            CSR_LONG_MAX:      long_max_ff      <= csr_wdata[WIDTH_W-1:0];
            CSR_TRIGGER_LEVEL: trigger_level_ff <= csr_wdata[RSSI_W-1:0];
            CSR_WINDOW_POLLS:  window_polls_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_GAP_LIMIT:     gap_limit_ff     <= csr_wdata[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic              in_valid_ff;
   logic              in_func_ff;
   logic [TIME_W-1:0] in_time_ff;
   logic [RSSI_W-1:0] in_rssi_ff;
   logic              rsp_valid_ff;
   logic              proc;
   logic              req_take;

   assign proc      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !proc;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_func;
         in_time_ff <= req_time_us;
         in_rssi_ff <= req_rssi_byte;
      end
   end

   // classifier state
   logic [TIME_W-1:0] last_edge_ff, last_edge_in;
   logic              armed_ff, armed_in;
   logic              marker_ff, marker_in;
   count_type         poll_cnt_ff, poll_cnt_in;
   count_type         edge_cnt_ff, edge_cnt_in;
   count_type         short_cnt_ff, short_cnt_in;
   count_type         long_cnt_ff, long_cnt_in;

   logic [TIME_W-1:0] interval;
   logic              is_short, is_long, is_gap, report;
   class_type         cls;
   count_type         edge_out, short_out, long_out;

   assign interval = in_time_ff - last_edge_ff;
   assign is_short = (interval > TIME_W'(short_min_ff)) && (interval < TIME_W'(short_max_ff));
   assign is_long  = (interval > TIME_W'(long_min_ff)) && (interval < TIME_W'(long_max_ff));
   assign is_gap   = interval > TIME_W'(gap_limit_ff);

   always_comb begin
      last_edge_in = last_edge_ff;
      armed_in     = armed_ff;
      marker_in    = marker_ff;
      poll_cnt_in  = poll_cnt_ff;
      edge_cnt_in  = edge_cnt_ff;
      short_cnt_in = short_cnt_ff;
      long_cnt_in  = long_cnt_ff;
      cls          = CLASS_NONE;
      report       = 1'b0;
      if (in_func_ff == FUNC_EDGE) begin
         last_edge_in = in_time_ff;
         edge_cnt_in  = sat_inc(edge_cnt_ff);
         if (armed_ff) begin
            if (is_short) short_cnt_in = sat_inc(short_cnt_ff);
            if (is_long)  long_cnt_in  = sat_inc(long_cnt_ff);
            marker_in = is_short || is_long;
            cls = is_short ? CLASS_SHORT : (is_long ? CLASS_LONG : CLASS_INVALID);
         end
      end else begin
         if (armed_ff) begin
            if (is_gap) begin
               marker_in = 1'b0;
               cls       = CLASS_GAP;
            end
         end else if (in_rssi_ff <= trigger_level_ff) begin
            armed_in    = 1'b1;
            marker_in   = 1'b1;
            edge_cnt_in = '0;
         end
         if (armed_in) begin
            poll_cnt_in = sat_inc(poll_cnt_ff);
            report      = poll_cnt_in >= window_polls_ff;
         end
      end
      edge_out  = edge_cnt_in;
      short_out = short_cnt_in;
      long_out  = long_cnt_in;
      if (report) begin
         edge_cnt_in  = '0;
         short_cnt_in = '0;
         long_cnt_in  = '0;
         poll_cnt_in  = '0;
         marker_in    = 1'b0;
         armed_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         armed_ff     <= 1'b0;
         marker_ff    <= 1'b0;
         poll_cnt_ff  <= '0;
         edge_cnt_ff  <= '0;
         short_cnt_ff <= '0;
         long_cnt_ff  <= '0;
      end else if (proc) begin
         last_edge_ff <= last_edge_in;
         armed_ff     <= armed_in;
         marker_ff    <= marker_in;
         poll_cnt_ff  <= poll_cnt_in;
         edge_cnt_ff  <= edge_cnt_in;
         short_cnt_ff <= short_cnt_in;
         long_cnt_ff  <= long_cnt_in;
      end
   end

   // result register
   logic      rsp_marker_ff, rsp_armed_ff, rsp_report_ff;
   class_type rsp_class_ff;
   count_type rsp_edge_ff, rsp_short_ff, rsp_long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         rsp_marker_ff <= marker_in;
         rsp_class_ff  <= cls;
         rsp_armed_ff  <= armed_in;
         rsp_report_ff <= report;
         rsp_edge_ff   <= edge_out;
         rsp_short_ff  <= short_out;
         rsp_long_ff   <= long_out;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_marker      = rsp_marker_ff;
   assign rsp_pulse_class = rsp_class_ff;
   assign rsp_armed       = rsp_armed_ff;
   assign rsp_report      = rsp_report_ff;
   assign rsp_edge_total  = rsp_edge_ff;
   assign rsp_short_total = rsp_short_ff;
   assign rsp_long_total  = rsp_long_ff;

`ifndef SYNTHESIS
   // a closing window always leaves capture disarmed with the marker low
   a_report_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report |-> !rsp_armed && !rsp_marker)
      else $error("report without disarm");

   // a gap always drops the marker and only happens while capture is armed (the same poll may close the window)
   a_gap_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pulse_class == CLASS_GAP) |-> !rsp_marker && (rsp_armed || rsp_report))
      else $error("gap with marker high");

   // state only moves on a processed transfer
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !proc |=> $stable(armed_ff) && $stable(edge_cnt_ff) && $stable(last_edge_ff))
      else $error("state changed without a transfer");

   // a stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !proc)
      else $error("result overwritten under stall");
`endif

endmodule
